// File: rtl/xrg_pkg.sv
// ----------------------------------------------------------------------------
// xrg_pkg: shared definitions for the xoshiro random generator
// Widths, mixing constants, datapath command codes and the command and status
// structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package xrg_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned HALF_W    = 32;
  localparam int unsigned STREAM_W  = 32;
  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned STEP_W    = 2;

  localparam logic [STEP_W-1:0] MUL_LAST_STEP = 2'd2;

  localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
  localparam logic [WORD_W-1:0] STREAM_MUL  = 64'hD1B5_4A32_D192_ED03;

  localparam int unsigned MIX_SHIFT_A = 30;
  localparam int unsigned MIX_SHIFT_B = 27;
  localparam int unsigned MIX_SHIFT_C = 31;
  localparam int unsigned XS_SHIFT    = 17;
  localparam int unsigned XS_ROT      = 45;
  localparam int unsigned OUT_ROT     = 7;

  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef enum logic [3:0] {
    DP_NOP      = 4'd0,
    DP_LATCH    = 4'd1,
    DP_DRAW     = 4'd2,
    DP_MUL0     = 4'd3,
    DP_MUL1     = 4'd4,
    DP_MUL2     = 4'd5,
    DP_ACC_INIT = 4'd6,
    DP_ACC_STEP = 4'd7,
    DP_FOLD     = 4'd8,
    DP_STORE    = 4'd9
  } dp_op_t;

  typedef enum logic [1:0] {
    MC_STREAM = 2'd0,
    MC_MIX_A  = 2'd1,
    MC_MIX_B  = 2'd2
  } mul_const_t;

  typedef struct packed {
    dp_op_t           op;
    mul_const_t       cnst;
    logic [IDX_W-1:0] word_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  function automatic logic [WORD_W-1:0] mul_const_value(input mul_const_t sel);
    logic [WORD_W-1:0] val;
    case (sel)
      MC_MIX_A: val = MIX_MUL_A;
      MC_MIX_B: val = MIX_MUL_B;
      default:  val = STREAM_MUL;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/xrg_if.sv
// ----------------------------------------------------------------------------
// xrg_if: request and result channels of the xoshiro random generator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface xrg_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [xrg_pkg::WORD_W-1:0]    seed_value;
  logic [xrg_pkg::STREAM_W-1:0]  stream_id;

  modport source(output valid, req_type, seed_value, stream_id, input ready);
  modport sink(input valid, req_type, seed_value, stream_id, output ready);
endinterface

interface xrg_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [xrg_pkg::WORD_W-1:0] random_word;

  modport source(output valid, random_word, input ready);
  modport sink(input valid, random_word, output ready);
endinterface

// File: rtl/xoshiro_random_generator.sv
// ----------------------------------------------------------------------------
// xoshiro_random_generator: xoshiro256** generator with splitmix64 seeding
// Draw beats return one 64-bit word each; seed beats reload the state.
// ----------------------------------------------------------------------------
// A draw result is valid in the cycle after its request beat.
// One draw per cycle while each result is taken as it goes; a held result stalls requests.
// A seed beat occupies the block through the accept cycle, the stream multiply and
// a step to mix in the seed, then for each state word through the step add, two
// multiplies on one 32x32 multiplier, a fold and a store.
// Reset clears all four state words to zero and empties the result register.
module xoshiro_random_generator (
  input  logic      clk,
  input  logic      rst_n,
  xrg_req_if.sink   in_ch,
  xrg_rsp_if.source out_ch
);

  xrg_pkg::dp_cmd_t    cmd;
  xrg_pkg::dp_status_t status;

  xrg_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_ready   (out_ch.ready),
    .status      (status),
    .cmd         (cmd)
  );

  xrg_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .seed_value  (in_ch.seed_value),
    .stream_id   (in_ch.stream_id),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .random_word (out_ch.random_word),
    .status      (status)
  );

endmodule

// File: rtl/xrg_ctrl.sv
// ----------------------------------------------------------------------------
// xrg_ctrl: sequencer of the xoshiro random generator
// Accepts request beats and steps the datapath through the seeding sequence
// of one stream multiply and four splitmix rounds.
// ----------------------------------------------------------------------------
module xrg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_req_type,
  output logic                in_ready,
  input  logic                out_ready,
  input  xrg_pkg::dp_status_t status,
  output xrg_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_MUL      = 6'b000010,
    ST_ACC_INIT = 6'b000100,
    ST_ACC_STEP = 6'b001000,
    ST_FOLD     = 6'b010000,
    ST_STORE    = 6'b100000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [xrg_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [xrg_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  xrg_pkg::mul_const_t            phase_r, phase_nxt;
  logic                           in_fire;

  assign in_ready = (state_r == ST_IDLE) && (!status.out_busy || out_ready);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    idx_nxt      = idx_r;
    phase_nxt    = phase_r;
    cmd.op       = xrg_pkg::DP_NOP;
    cmd.cnst     = phase_r;
    cmd.word_idx = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req_type == xrg_pkg::REQ_DRAW) begin
            cmd.op = xrg_pkg::DP_DRAW;
          end else begin
            cmd.op    = xrg_pkg::DP_LATCH;
            state_nxt = ST_MUL;
            phase_nxt = xrg_pkg::MC_STREAM;
            step_nxt  = '0;
            idx_nxt   = '0;
          end
        end
      end
      ST_MUL: begin
        case (step_r)
          2'd0:    cmd.op = xrg_pkg::DP_MUL0;
          2'd1:    cmd.op = xrg_pkg::DP_MUL1;
          default: cmd.op = xrg_pkg::DP_MUL2;
        endcase
        if (step_r == xrg_pkg::MUL_LAST_STEP) begin
          step_nxt = '0;
          case (phase_r)
            xrg_pkg::MC_STREAM: state_nxt = ST_ACC_INIT;
            xrg_pkg::MC_MIX_A:  state_nxt = ST_FOLD;
            default:            state_nxt = ST_STORE;
          endcase
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_ACC_INIT: begin
        cmd.op    = xrg_pkg::DP_ACC_INIT;
        state_nxt = ST_ACC_STEP;
      end
      ST_ACC_STEP: begin
        cmd.op    = xrg_pkg::DP_ACC_STEP;
        phase_nxt = xrg_pkg::MC_MIX_A;
        state_nxt = ST_MUL;
      end
      ST_FOLD: begin
        cmd.op    = xrg_pkg::DP_FOLD;
        phase_nxt = xrg_pkg::MC_MIX_B;
        state_nxt = ST_MUL;
      end
      ST_STORE: begin
        cmd.op = xrg_pkg::DP_STORE;
        if (idx_r == xrg_pkg::IDX_W'(xrg_pkg::NUM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_ACC_STEP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      idx_r   <= '0;
      phase_r <= xrg_pkg::MC_STREAM;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// File: rtl/xrg_dp.sv
// ----------------------------------------------------------------------------
// xrg_dp: datapath of the xoshiro random generator
// Holds the four state words, the draw logic with its result register, and a
// shared 32x32 multiplier that builds each 64-bit product in three steps.
// ----------------------------------------------------------------------------
module xrg_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  xrg_pkg::dp_cmd_t              cmd,
  input  logic [xrg_pkg::WORD_W-1:0]    seed_value,
  input  logic [xrg_pkg::STREAM_W-1:0]  stream_id,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [xrg_pkg::WORD_W-1:0]    random_word,
  output xrg_pkg::dp_status_t           status
);

  localparam int unsigned W = xrg_pkg::WORD_W;
  localparam int unsigned H = xrg_pkg::HALF_W;

  logic [W-1:0] s_r [xrg_pkg::NUM_WORDS];
  logic [W-1:0] seed_r, z_r, mac_r, acc_r, res_r;
  logic         out_valid_r, out_valid_nxt;

  logic [W-1:0] cval, prod, mac_sum, acc_inc, draw_res;
  logic [W-1:0] s1x5, s1x5_rot, t_val, n0, n1, n2, n3;
  logic [H-1:0] mul_a, mul_b;

  assign cval  = xrg_pkg::mul_const_value(cmd.cnst);
  assign mul_a = (cmd.op == xrg_pkg::DP_MUL2) ? z_r[W-1:H] : z_r[H-1:0];
  assign mul_b = (cmd.op == xrg_pkg::DP_MUL1) ? cval[W-1:H] : cval[H-1:0];
  assign prod  = {{H{1'b0}}, mul_a} * {{H{1'b0}}, mul_b};
  assign mac_sum = mac_r + {prod[H-1:0], {H{1'b0}}};
  assign acc_inc = acc_r + xrg_pkg::GOLDEN_STEP;

  assign s1x5     = s_r[1] + (s_r[1] << 2);
  assign s1x5_rot = (s1x5 << xrg_pkg::OUT_ROT) | (s1x5 >> (W - xrg_pkg::OUT_ROT));
  assign draw_res = s1x5_rot + (s1x5_rot << 3);

  assign t_val = s_r[1] << xrg_pkg::XS_SHIFT;
  assign n2    = s_r[2] ^ s_r[0];
  assign n3    = s_r[3] ^ s_r[1];
  assign n1    = s_r[1] ^ n2;
  assign n0    = s_r[0] ^ n3;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.op == xrg_pkg::DP_DRAW) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < xrg_pkg::NUM_WORDS; i++) begin
        s_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (cmd.op)
        xrg_pkg::DP_DRAW: begin
          s_r[0] <= n0;
          s_r[1] <= n1;
          s_r[2] <= n2 ^ t_val;
          s_r[3] <= (n3 << xrg_pkg::XS_ROT) | (n3 >> (W - xrg_pkg::XS_ROT));
        end
        xrg_pkg::DP_STORE: begin
          s_r[cmd.word_idx] <= mac_r ^ (mac_r >> xrg_pkg::MIX_SHIFT_C);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      xrg_pkg::DP_LATCH: begin
        seed_r <= seed_value;
        z_r    <= {{(W - xrg_pkg::STREAM_W){1'b0}}, stream_id};
      end
      xrg_pkg::DP_DRAW:     res_r <= draw_res;
      xrg_pkg::DP_MUL0:     mac_r <= prod;
      xrg_pkg::DP_MUL1,
      xrg_pkg::DP_MUL2:     mac_r <= mac_sum;
      xrg_pkg::DP_ACC_INIT: acc_r <= seed_r ^ mac_r;
      xrg_pkg::DP_ACC_STEP: begin
        acc_r <= acc_inc;
        z_r   <= acc_inc ^ (acc_inc >> xrg_pkg::MIX_SHIFT_A);
      end
      xrg_pkg::DP_FOLD:     z_r <= mac_r ^ (mac_r >> xrg_pkg::MIX_SHIFT_B);
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign random_word     = res_r;
  assign status.out_busy = out_valid_r;

endmodule

// File: rtl/xrg_checker.sv
// ----------------------------------------------------------------------------
// xrg_checker: port-level checks for the xoshiro random generator
// Watches the request and result channels and flags sequencing errors.
// ----------------------------------------------------------------------------
module xrg_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_req_type,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [xrg_pkg::WORD_W-1:0] random_word
);

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(random_word))
    else $error("Stalled result beat changed or dropped.");

  a_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_req_type == xrg_pkg::REQ_DRAW) |=> out_valid)
    else $error("Draw beat gave no result.");

  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_req_type == xrg_pkg::REQ_SEED) |=> !in_ready)
    else $error("Request taken while seeding.");

  a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_req_type == xrg_pkg::REQ_SEED) && !out_valid |=> !out_valid)
    else $error("Seed beat produced a result.");

endmodule

bind xoshiro_random_generator xrg_checker u_xrg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .random_word (out_ch.random_word)
);

// File: tb/sv/tb_xoshiro_random_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xoshiro_random_generator: self-checking bench for the xoshiro generator
// Walks a short table of seed and draw beats, then about 650 random beats
// with random pauses on both channels and one long result hold-off. Each draw
// word is compared with an in-bench xoshiro256** and splitmix64 model.
// ----------------------------------------------------------------------------
module tb_xoshiro_random_generator;

  localparam int RANDOM_BEATS = 650;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam int REPORT_MAX   = 10;
  localparam int DIR_ROWS     = 22;

  localparam logic [xrg_pkg::WORD_W-1:0]   ALL_ONES64 = '1;
  localparam logic [xrg_pkg::STREAM_W-1:0] ALL_ONES32 = '1;

  typedef struct packed {
    logic                         req;
    logic [xrg_pkg::WORD_W-1:0]   seed;
    logic [xrg_pkg::STREAM_W-1:0] stream;
    logic                         pinned;
    logic [xrg_pkg::WORD_W-1:0]   pin_word;
  } stim_row_t;

  typedef struct packed {
    logic                       pinned;
    logic [xrg_pkg::WORD_W-1:0] word;
  } pin_t;

  logic clk = 1'b0;
  logic rst_n;

  xrg_req_if req_ch ();
  xrg_rsp_if rsp_ch ();

  xoshiro_random_generator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  always #5 clk = ~clk;

  logic [xrg_pkg::WORD_W-1:0] xs_state [xrg_pkg::NUM_WORDS] = '{default: '0};
  logic [xrg_pkg::WORD_W-1:0] word_q [$];
  pin_t                       pin_q [$];
  int                         fail_count    = 0;
  int                         seeds_taken   = 0;
  int                         draws_taken   = 0;
  int                         words_checked = 0;
  bit                         hold_done     = 1'b0;

  // Draw rows taken before any seed must return zero.
  stim_row_t dir_table [DIR_ROWS] = '{
    '{xrg_pkg::REQ_DRAW, ALL_ONES64, ALL_ONES32, 1'b1, 64'h0},
    '{xrg_pkg::REQ_DRAW, 64'h0, 32'h0, 1'b1, 64'h0},
    '{xrg_pkg::REQ_SEED, 64'h0, 32'h0, 1'b0, 64'h0},
    '{xrg_pkg::REQ_DRAW, 64'h0, 32'h0, 1'b0, 64'h0},
    '{xrg_pkg::REQ_DRAW, 64'h0, 32'h0, 1'b0, 64'h0},
    '{xrg_pkg::REQ_SEED, ALL_ONES64, ALL_ONES32, 1'b0, 64'h0},
    '{xrg_pkg::REQ_DRAW, 64'h0, 32'h0, 1'b0, 64'h0},
    '{xrg_pkg::REQ_DRAW, ALL_ONES64, ALL_ONES32, 1'b0, 64'h0},
    '{xrg_pkg::REQ_SEED, ALL_ONES64, 32'h0, 1'b0, 64'h0},
    '{xrg_pkg::REQ_DRAW, 64'h0, 32'h0, 1'b0, 64'h0},
    '{xrg_pkg::REQ_SEED, 64'h0, ALL_ONES32, 1'b0, 64'h0},
    '{xrg_pkg::REQ_DRAW, 64'h0, 32'h0, 1'b0, 64'h0},
    '{xrg_pkg::REQ_SEED, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, 64'h0},
    '{xrg_pkg::REQ_SEED, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0, 64'h0},
    '{xrg_pkg::REQ_DRAW, 64'h1234_5678_9ABC_DEF0, 32'hDEAD_BEEF, 1'b0, 64'h0},
    '{xrg_pkg::REQ_DRAW, 64'h0, 32'h0, 1'b0, 64'h0},
    '{xrg_pkg::REQ_SEED, 64'h8000_0000_0000_0001, 32'h8000_0001, 1'b0, 64'h0},
    '{xrg_pkg::REQ_DRAW, 64'h0, 32'h0, 1'b0, 64'h0},
    '{xrg_pkg::REQ_DRAW, 64'h0, 32'h0, 1'b0, 64'h0},
    '{xrg_pkg::REQ_DRAW, 64'h0, 32'h0, 1'b0, 64'h0},
    '{xrg_pkg::REQ_SEED, 64'h1, 32'h1, 1'b0, 64'h0},
    '{xrg_pkg::REQ_DRAW, 64'h0, 32'h0, 1'b0, 64'h0}
  };

  function automatic logic [xrg_pkg::WORD_W-1:0] rotl64(
      input logic [xrg_pkg::WORD_W-1:0] v, input int unsigned k);
    return (v << k) | (v >> (xrg_pkg::WORD_W - k));
  endfunction

  function automatic logic [xrg_pkg::WORD_W-1:0] splitmix_finish(
      input logic [xrg_pkg::WORD_W-1:0] z);
    logic [xrg_pkg::WORD_W-1:0] m;
    m = (z ^ (z >> xrg_pkg::MIX_SHIFT_A)) * xrg_pkg::MIX_MUL_A;
    m = (m ^ (m >> xrg_pkg::MIX_SHIFT_B)) * xrg_pkg::MIX_MUL_B;
    return m ^ (m >> xrg_pkg::MIX_SHIFT_C);
  endfunction

  function automatic void reseed_model(input logic [xrg_pkg::WORD_W-1:0] seed,
                                       input logic [xrg_pkg::STREAM_W-1:0] stream);
    logic [xrg_pkg::WORD_W-1:0] acc;
    logic [xrg_pkg::WORD_W-1:0] wide_stream;
    wide_stream = {{(xrg_pkg::WORD_W-xrg_pkg::STREAM_W){1'b0}}, stream};
    acc = seed ^ (wide_stream * xrg_pkg::STREAM_MUL);
    for (int i = 0; i < xrg_pkg::NUM_WORDS; i++) begin
      acc = acc + xrg_pkg::GOLDEN_STEP;
      xs_state[i] = splitmix_finish(acc);
    end
  endfunction

  function automatic logic [xrg_pkg::WORD_W-1:0] advance_xoshiro();
    logic [xrg_pkg::WORD_W-1:0] word;
    logic [xrg_pkg::WORD_W-1:0] shifted;
    word = rotl64(xs_state[1] * 64'd5, xrg_pkg::OUT_ROT) * 64'd9;
    shifted = xs_state[1] << xrg_pkg::XS_SHIFT;
    xs_state[2] = xs_state[2] ^ xs_state[0];
    xs_state[3] = xs_state[3] ^ xs_state[1];
    xs_state[1] = xs_state[1] ^ xs_state[2];
    xs_state[0] = xs_state[0] ^ xs_state[3];
    xs_state[2] = xs_state[2] ^ shifted;
    xs_state[3] = rotl64(xs_state[3], xrg_pkg::XS_ROT);
    return word;
  endfunction

  function automatic int random_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [xrg_pkg::WORD_W-1:0] random_seed_field();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return ALL_ONES64;
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [xrg_pkg::STREAM_W-1:0] random_stream_field();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return ALL_ONES32;
    return $urandom();
  endfunction

  task automatic send_beat(input logic req, input logic [xrg_pkg::WORD_W-1:0] seed,
                           input logic [xrg_pkg::STREAM_W-1:0] stream, input pin_t pin);
    pin_q.push_back(pin);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= req;
    req_ch.seed_value <= seed;
    req_ch.stream_id  <= stream;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= 1'($urandom_range(0, 1));
      req_ch.seed_value <= {$urandom(), $urandom()};
      req_ch.stream_id  <= $urandom();
      repeat (cycles) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : beat_monitor
    pin_t                       pin;
    logic [xrg_pkg::WORD_W-1:0] want;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        pin = '0;
        if (pin_q.size() != 0) pin = pin_q.pop_front();
        if (req_ch.req_type == xrg_pkg::REQ_SEED) begin
          reseed_model(req_ch.seed_value, req_ch.stream_id);
          seeds_taken++;
        end else begin
          want = advance_xoshiro();
          if (pin.pinned) want = pin.word;
          word_q.push_back(want);
          draws_taken++;
        end
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (word_q.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("[%0t] unexpected result beat: random_word %h", $realtime,
                     rsp_ch.random_word);
          fail_count++;
        end else begin
          want = word_q.pop_front();
          if (rsp_ch.random_word !== want) begin
            if (fail_count < REPORT_MAX)
              $display("[%0t] random_word mismatch: expected %h, actual %h", $realtime,
                       want, rsp_ch.random_word);
            fail_count++;
          end
          words_checked++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t] no beat moved for %0d cycles", $realtime, IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : result_sink
    int run;
    int stall;
    rsp_ch.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!hold_done && words_checked >= 60) begin
        hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
        rsp_ch.ready <= 1'b1;
        repeat (run) @(posedge clk);
        stall = random_pause();
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    logic                         req;
    logic [xrg_pkg::WORD_W-1:0]   seed;
    logic [xrg_pkg::STREAM_W-1:0] stream;
    pin_t                         pin;
    rst_n             = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = xrg_pkg::REQ_SEED;
    req_ch.seed_value = '0;
    req_ch.stream_id  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      pin.pinned = dir_table[i].pinned;
      pin.word   = dir_table[i].pin_word;
      send_beat(dir_table[i].req, dir_table[i].seed, dir_table[i].stream, pin);
      idle_sender(random_pause());
    end

    // Mostly draws, with an occasional reseed; every fourth block of 50 beats
    // runs without pauses on the request side.
    pin = '0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      req    = ($urandom_range(0, 99) < 8) ? xrg_pkg::REQ_SEED : xrg_pkg::REQ_DRAW;
      seed   = random_seed_field();
      stream = random_stream_field();
      send_beat(req, seed, stream, pin);
      if ((n / 50) % 4 != 2) idle_sender(random_pause());
    end
    req_ch.valid <= 1'b0;

    while (word_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d seed beats and %0d draw beats; %0d result words checked.",
             seeds_taken, draws_taken, words_checked);
    $display("Result beats with wrong or unexpected words: %0d.", fail_count);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
